@@ hdl/mtf_pkg.sv @@
// Shared widths, the token record and the control record of the move-to-front codec.
`default_nettype none

package mtf_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int SYM_W = 8;

   // Mode codes of the decode_mode register
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Token that walks the cell chain, one cell per cycle
   typedef struct packed {
      logic             valid;
      logic             done;    // hit seen, pass through untouched
      logic             wr;      // write carry into the visited cell
      logic             front;   // hit value must be loaded into the front cell
      logic [SYM_W-1:0] carry;   // old value of the previous cell
      logic [SYM_W-1:0] result;
   } mtf_tok_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic             init;        // restore identity list
      logic             decode;
      logic [SYM_W-1:0] key;
      logic             front_load;
      logic [SYM_W-1:0] front_value;
   } mtf_ctl_type;

endpackage

`default_nettype wire

@@ hdl/mtf_cell.sv @@
// One entry of the recency list together with the token stage that follows it.
`default_nettype none

module mtf_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  wire [mtf_pkg::SYM_W-1:0]   cell_index,
   input  mtf_pkg::mtf_ctl_type       ctl,
   input  wire                        front_en,
   input  mtf_pkg::mtf_tok_type       tok_prev,
   output mtf_pkg::mtf_tok_type       tok_next
);
   import mtf_pkg::*;

   logic [SYM_W-1:0] value_ff, value_in;
   mtf_tok_type      tok_ff, tok_in;
   logic             active;
   logic             hit;

   always_comb begin
      active = tok_prev.valid && !tok_prev.done;
      hit    = (ctl.decode == MODE_DECODE) ? (cell_index == ctl.key) : (value_ff == ctl.key);

      value_in = value_ff;
      if (ctl.init) begin
         value_in = cell_index;
      end else if (front_en) begin
         value_in = ctl.front_value;
      end else if (active && tok_prev.wr) begin
         value_in = tok_prev.carry;
      end

      // hand the old entry on, or finish the walk on a hit
      tok_in = tok_prev;
      if (active) begin
         tok_in.done  = hit;
         tok_in.wr    = 1'b1;
         tok_in.carry = value_ff;
         if (hit) begin
            tok_in.result = (ctl.decode == MODE_DECODE) ? value_ff : cell_index;
            tok_in.front  = (ctl.decode == MODE_DECODE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff     <= cell_index;
         tok_ff.valid <= 1'b0;
      end else begin
         value_ff     <= value_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.done   <= tok_in.done;
      tok_ff.wr     <= tok_in.wr;
      tok_ff.front  <= tok_in.front;
      tok_ff.carry  <= tok_in.carry;
      tok_ff.result <= tok_in.result;
   end

   assign tok_next = tok_ff;

endmodule

`default_nettype wire

@@ hdl/move_to_front_codec_top.sv @@
// Move-to-front codec top level: handshakes, control and the chain of list cells.
//
// Usage:
//   csr_valid/csr_ready/csr_decode_mode writes the mode (0 encode bytes to
//   ranks, 1 decode ranks to bytes); write it only while the block is idle.
//   req_valid/req_ready carries one item: req_symbol_in and req_block_start.
//   A set block_start restores the identity list before the item is handled.
//   rsp_valid/rsp_ready returns one rsp_symbol_out for every item, in order.
// Operation:
//   Each item launches a token that walks the chain of ALPHABET_SIZE cells,
//   one cell per cycle, shifting entries back behind it and stopping work at
//   the matching entry. As the token leaves the chain its result goes to
//   the output register if that is free. One item is in the chain at a
//   time: a new item is taken only once the last result is in that register.
//   While a result waits on a stalled receiver the next item is still taken;
//   its result is held in a one-deep holding register, and further items are
//   refused until that register drains.
// Reset: the list returns to the identity, the mode to encode, and both
//   channels to empty.
`default_nettype none

module move_to_front_codec_top (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire                       csr_decode_mode,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire [mtf_pkg::SYM_W-1:0]  req_symbol_in,
   input  wire                       req_block_start,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [mtf_pkg::SYM_W-1:0] rsp_symbol_out
);
   import mtf_pkg::*;

   logic             decode_mode_ff, decode_mode_in;
   logic             busy_ff, busy_in;
   logic [SYM_W-1:0] key_ff, key_in;
   mtf_tok_type      launch_ff, launch_in;
   logic             pend_ff, pend_in;
   logic [SYM_W-1:0] pend_sym_ff, pend_sym_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_sym_ff, rsp_sym_in;

   mtf_ctl_type      ctl;
   mtf_tok_type      link [ALPHABET_SIZE+1];
   mtf_tok_type      end_tok;
   logic             req_accept;
   logic             slot_free;
   logic             out_of_range;

   assign csr_ready      = 1'b1;
   assign req_ready      = !busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_symbol_out = rsp_sym_ff;

   assign req_accept   = req_valid && req_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign out_of_range = ({1'b0, req_symbol_in} >= (SYM_W+1)'(ALPHABET_SIZE));
   assign end_tok      = link[ALPHABET_SIZE];

   always_comb begin
      ctl.init        = req_accept && req_block_start;
      ctl.decode      = decode_mode_ff;
      ctl.key         = key_ff;
      ctl.front_load  = end_tok.valid && end_tok.front;
      ctl.front_value = end_tok.result;
   end

   always_comb begin
      decode_mode_in = decode_mode_ff;
      if (csr_valid && csr_ready) begin
         decode_mode_in = csr_decode_mode;
      end

      key_in          = key_ff;
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;
      if (req_accept) begin
         key_in           = req_symbol_in;
         launch_in.valid  = 1'b1;
         launch_in.done   = out_of_range;   // no list change, result zero
         launch_in.wr     = (decode_mode_ff == MODE_ENCODE);
         launch_in.front  = 1'b0;
         launch_in.carry  = req_symbol_in;
         launch_in.result = '0;
      end

      busy_in      = busy_ff;
      pend_in      = pend_ff;
      pend_sym_in  = pend_sym_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      priority if (end_tok.valid) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_sym_in   = end_tok.result;
            busy_in      = 1'b0;
         end else begin
            pend_in     = 1'b1;
            pend_sym_in = end_tok.result;
         end
      end else if (pend_ff && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = pend_sym_ff;
         pend_in      = 1'b0;
         busy_in      = 1'b0;
      end else begin
         // hold
      end
      if (req_accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff  <= MODE_ENCODE;
         busy_ff         <= 1'b0;
         launch_ff.valid <= 1'b0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         decode_mode_ff  <= decode_mode_in;
         busy_ff         <= busy_in;
         launch_ff.valid <= launch_in.valid;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      key_ff           <= key_in;
      launch_ff.done   <= launch_in.done;
      launch_ff.wr     <= launch_in.wr;
      launch_ff.front  <= launch_in.front;
      launch_ff.carry  <= launch_in.carry;
      launch_ff.result <= launch_in.result;
      pend_sym_ff      <= pend_sym_in;
      rsp_sym_ff       <= rsp_sym_in;
   end

   assign link[0] = launch_ff;

   for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
      logic front_en;
      if (k == 0) begin : g_front
         assign front_en = ctl.front_load;
      end else begin : g_rest
         assign front_en = 1'b0;
      end
      mtf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SYM_W'(k)),
         .ctl        (ctl),
         .front_en   (front_en),
         .tok_prev   (link[k]),
         .tok_next   (link[k+1])
      );
   end

   // a token only leaves the chain for an item still counted as in flight
   a_end_while_busy : assert property (@(posedge clock) disable iff (reset)
      end_tok.valid |-> busy_ff)
      else $error("token left the chain with no item in flight");

   a_launch_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> launch_ff.valid && busy_ff)
      else $error("accepted item did not launch a token");

   a_pend_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> rsp_valid_ff && busy_ff)
      else $error("held result without a waiting response");

   a_front_only_decode : assert property (@(posedge clock) disable iff (reset)
      ctl.front_load |-> (decode_mode_ff == MODE_DECODE))
      else $error("front load while encoding");

   a_no_end_with_pend : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !end_tok.valid)
      else $error("second token arrived over a held result");

endmodule

`default_nettype wire

@@ tb/tb_move_to_front_codec_top.sv @@
// Self-checking testbench for the move-to-front codec top level.
module tb_move_to_front_codec_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mtf_pkg::*;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             start;
   } mtf_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_decode_mode = MODE_ENCODE;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [SYM_W-1:0] req_symbol_in = '0;
   logic             req_block_start = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [SYM_W-1:0] rsp_symbol_out;

   mtf_item_type     pending_items[$];
   logic [SYM_W-1:0] expected_symbols[$];
   logic [SYM_W-1:0] recency_list[ALPHABET_SIZE];
   logic             list_mode = MODE_ENCODE;

   int  send_gap = 0;
   int  recv_gap = 0;
   bit  idling_on = 1'b1;
   bit  heavy_stall = 1'b0;
   int  fail_count = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  mode_writes = 0;
   logic [SYM_W-1:0] last_sym = '0;

   move_to_front_codec_top u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_decode_mode (csr_decode_mode),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol_in   (req_symbol_in),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol_out  (rsp_symbol_out)
   );

   always #5 clock = ~clock;

   function automatic void load_identity_list();
      for (int i = 0; i < ALPHABET_SIZE; i++) recency_list[i] = i[SYM_W-1:0];
   endfunction

   // Every byte lies inside the alphabet, so there is no out-of-range case here.
   function automatic logic [SYM_W-1:0] mtf_step(input logic [SYM_W-1:0] sym,
                                                 input logic start);
      int               pos;
      logic [SYM_W-1:0] moved;
      logic [SYM_W-1:0] coded;
      if (start) load_identity_list();
      pos = 0;
      if (list_mode == MODE_DECODE) begin
         pos = int'(sym);
         coded = recency_list[pos];
      end else begin
         for (int r = ALPHABET_SIZE - 1; r >= 0; r--)
            if (recency_list[r] == sym) pos = r;
         coded = pos[SYM_W-1:0];
      end
      moved = recency_list[pos];
      for (int k = pos; k > 0; k--) recency_list[k] = recency_list[k-1];
      recency_list[0] = moved;
      return coded;
   endfunction

   // Request driver
   always @(posedge clock) begin : req_driver
      mtf_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            item = pending_items.pop_front();
            req_valid       <= 1'b1;
            req_symbol_in   <= item.sym;
            req_block_start <= item.start;
            if (idling_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 19);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: stall bursts, long chains of them when heavy_stall is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else if (recv_gap != 0) begin
         rsp_ready <= 1'b0;
         recv_gap  <= recv_gap - 1;
      end else if (idling_on && $urandom_range(0, 15) < (heavy_stall ? 15 : 3)) begin
         rsp_ready <= 1'b0;
         recv_gap  <= $urandom_range(1, 19) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on every accepted item, check every accepted result
   always @(posedge clock) begin : monitor
      logic [SYM_W-1:0] want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            list_mode = csr_decode_mode;
            mode_writes++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               $error("symbol_out: result %0d arrived with no item outstanding",
                      rsp_symbol_out);
               fail_count++;
            end else begin
               want = expected_symbols.pop_front();
               results_checked++;
               if (rsp_symbol_out !== want) begin
                  $error("symbol_out mismatch: expected %0d, actual %0d", want,
                         rsp_symbol_out);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_symbols.push_back(mtf_step(req_symbol_in, req_block_start));
            items_sent++;
         end
      end
   end

   task automatic write_mode(input logic mode);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_decode_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold until every queued item has gone through and its result is back
   task automatic wait_drained();
      @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_symbols.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_item(input logic [SYM_W-1:0] sym, input logic start);
      mtf_item_type item;
      item.sym   = sym;
      item.start = start;
      pending_items.push_back(item);
   endtask

   task automatic queue_directed();
      push_item(8'd0,   1'b1);
      push_item(8'd255, 1'b0);
      push_item(8'd255, 1'b0);
      push_item(8'd0,   1'b0);
      push_item(8'd128, 1'b0);
      push_item(8'd1,   1'b0);
      push_item(8'hAA,  1'b0);
      push_item(8'h55,  1'b0);
      push_item(8'd255, 1'b1);
      push_item(8'd0,   1'b0);
      push_item(8'd0,   1'b1);
      push_item(8'd254, 1'b0);
   endtask

   // Blocks opened by block_start with random content; a few continue the old list
   task automatic queue_random(input int count);
      int               n;
      int               seq_len;
      int               pick;
      logic [SYM_W-1:0] sym;
      logic             start;
      n = 0;
      while (n < count) begin
         seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         for (int i = 0; i < seq_len && n < count; i++) begin
            if (i == 0) start = ($urandom_range(0, 9) != 0);
            else start = ($urandom_range(0, 31) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4) sym = SYM_W'($urandom_range(0, 255));
            else if (pick < 7) sym = SYM_W'($urandom_range(0, 7));
            else sym = last_sym;
            last_sym = sym;
            push_item(sym, start);
            n++;
         end
      end
   endtask

   initial begin
      load_identity_list();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_ENCODE);
      queue_directed();
      wait_drained();
      write_mode(MODE_DECODE);
      queue_directed();
      wait_drained();

      write_mode(MODE_ENCODE);
      queue_random(70);
      wait_drained();
      write_mode(MODE_DECODE);
      queue_random(70);
      wait_drained();

      heavy_stall = 1'b1;
      write_mode(MODE_ENCODE);
      queue_random(40);
      wait_drained();
      write_mode(MODE_DECODE);
      queue_random(40);
      wait_drained();
      heavy_stall = 1'b0;

      write_mode(MODE_ENCODE);
      queue_random(70);
      wait_drained();

      idling_on = 1'b0;
      write_mode(MODE_DECODE);
      queue_random(110);
      wait_drained();

      // drain the chain once more in case of a stray result
      repeat (ALPHABET_SIZE + 8) @(posedge clock);

      $display("Covered %0d items in encode and decode, %0d results checked, %0d mode writes,",
               items_sent, results_checked, mode_writes);
      $display("with sender gaps and receiver stalls, including long stall chains.");
      if (fail_count == 0 && expected_symbols.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ move_to_front_codec_top.f @@
hdl/mtf_pkg.sv
hdl/mtf_cell.sv
hdl/move_to_front_codec_top.sv
tb/tb_move_to_front_codec_top.sv
